/* hw/rtl/cdq_pkg.sv */
// Shared constants, codes and types for the circular deque core.
// Used by cdq_seq and circular_deque_with_resize_core.
package cdq_pkg;

	localparam int MAX_CAP = 1024;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = $clog2(MAX_CAP);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int MIN_CAP = 2;

	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_READ       = 3'd4;
	localparam logic [2:0] OP_WRITE      = 3'd5;
	localparam logic [2:0] OP_SEARCH     = 3'd6;
	localparam logic [2:0] OP_CLEAR      = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [DATA_W-1:0] read_data;
		logic [ADDR_W-1:0] found_position;
		logic [CNT_W-1:0]  count_now;
		logic [CNT_W-1:0]  capacity_now;
	} res_t;

endpackage

/* hw/rtl/cdq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/cdq_seq.sv */
// Sequencer of the circular deque: ring state, slot address unit and the
// step loops for search, resize and clearing. Depends on cdq_pkg.
module cdq_seq import cdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [ADDR_W-1:0] position,
	input  logic [DATA_W-1:0] value,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output mem_req_t          st_req,
	input  logic [DATA_W-1:0] st_rdata,
	output mem_req_t          scr_req,
	input  logic [DATA_W-1:0] scr_rdata
);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_SRCH_A = 4'd3;
	localparam logic [3:0] S_SRCH_B = 4'd4;
	localparam logic [3:0] S_CP_A   = 4'd5;
	localparam logic [3:0] S_CP_B   = 4'd6;
	localparam logic [3:0] S_WB_A   = 4'd7;
	localparam logic [3:0] S_WB_B   = 4'd8;
	localparam logic [3:0] S_PUSH   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  new_cap_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  lim_q;
	logic              init_q;
	logic [2:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [2:0]        status_q;
	logic [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0] fpos_q;

	logic [ADDR_W-1:0] mask;
	logic [ADDR_W-1:0] off;
	logic [ADDR_W-1:0] slot;
	logic              accept;
	logic              in_range;
	logic [CNT_W-1:0]  k_inc;
	logic [CNT_W-1:0]  cnt_dec;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign mask     = ADDR_W'(cap_q - CNT_W'(1));
	assign in_range = {1'b0, position} < cap_q;
	assign k_inc    = k_q + CNT_W'(1);
	assign cnt_dec  = count_q - CNT_W'(1);

	// The one slot address unit: head plus a logical offset, wrapped to capacity.
	always_comb begin
		off = k_q[ADDR_W-1:0];
		if (state_q == S_IDLE) begin
			off = (opcode == OP_READ || opcode == OP_WRITE) ? position
			                                                : count_q[ADDR_W-1:0];
		end else if (state_q == S_PUSH) begin
			off = (op_q == OP_PUSH_FRONT) ? '1 : count_q[ADDR_W-1:0];
		end
	end
	assign slot = (head_q + off) & mask;

	always_comb begin
		st_req       = '0;
		st_req.raddr = slot;
		scr_req       = '0;
		scr_req.raddr = k_q[ADDR_W-1:0];
		scr_req.waddr = k_q[ADDR_W-1:0];
		scr_req.wdata = st_rdata;
		scr_req.we    = (state_q == S_CP_B);
		unique case (state_q)
			S_IDLE: begin
				st_req.we    = accept && opcode == OP_WRITE && in_range;
				st_req.waddr = slot;
				st_req.wdata = value;
			end
			S_PUSH: begin
				st_req.we    = 1'b1;
				st_req.waddr = slot;
				st_req.wdata = val_q;
			end
			S_CLR: begin
				st_req.we    = 1'b1;
				st_req.waddr = k_q[ADDR_W-1:0];
			end
			S_WB_B: begin
				st_req.we    = 1'b1;
				st_req.waddr = k_q[ADDR_W-1:0];
				st_req.wdata = (k_q < count_q) ? scr_rdata : '0;
			end
			default: begin
			end
		endcase
	end

	assign res_valid          = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.read_data      = rdata_q;
	assign res.found_position = fpos_q;
	assign res.count_now      = count_q;
	assign res.capacity_now   = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			head_q    <= '0;
			count_q   <= '0;
			cap_q     <= CNT_W'(MIN_CAP);
			new_cap_q <= CNT_W'(MIN_CAP);
			k_q       <= '0;
			lim_q     <= CNT_W'(MAX_CAP);
			init_q    <= 1'b1;
		end else begin
			unique case (state_q)
				S_CLR: begin
					k_q <= k_inc;
					if (k_inc == lim_q) begin
						state_q <= init_q ? S_IDLE : S_DONE;
						init_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode;
						val_q    <= value;
						status_q <= ST_OK;
						rdata_q  <= '0;
						fpos_q   <= '0;
						k_q      <= '0;
						state_q  <= S_DONE;
						case (opcode) inside
							OP_PUSH_BACK, OP_PUSH_FRONT: begin
								if (count_q < cap_q) begin
									state_q <= S_PUSH;
								end else if (cap_q == CNT_W'(MAX_CAP)) begin
									status_q <= ST_FULL;
								end else begin
									new_cap_q <= cap_q << 1;
									lim_q     <= cap_q << 1;
									state_q   <= (count_q == '0) ? S_WB_A : S_CP_A;
								end
							end
							OP_POP_BACK, OP_POP_FRONT: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= cnt_dec;
									if (opcode == OP_POP_FRONT) begin
										head_q <= (head_q + ADDR_W'(1)) & mask;
									end
									if (cap_q > CNT_W'(MIN_CAP) && cnt_dec < (cap_q >> 2)) begin
										new_cap_q <= cap_q >> 1;
										lim_q     <= cap_q;
										state_q   <= (cnt_dec == '0) ? S_WB_A : S_CP_A;
									end
								end
							end
							OP_READ: begin
								if (in_range) begin
									state_q <= S_RD;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							OP_WRITE: begin
								if (!in_range) begin
									status_q <= ST_RANGE;
								end
							end
							OP_SEARCH: begin
								if (count_q == '0) begin
									status_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_SRCH_A;
								end
							end
							default: begin
								// Slots at or above the capacity are always zero,
								// so only the current capacity needs sweeping.
								lim_q   <= cap_q;
								head_q  <= '0;
								count_q <= '0;
								cap_q   <= CNT_W'(MIN_CAP);
								state_q <= S_CLR;
							end
						endcase
					end
				end
				S_RD: begin
					rdata_q <= st_rdata;
					state_q <= S_DONE;
				end
				S_SRCH_A: begin
					state_q <= S_SRCH_B;
				end
				S_SRCH_B: begin
					if (st_rdata == val_q) begin
						fpos_q  <= k_q[ADDR_W-1:0];
						state_q <= S_DONE;
					end else if (k_inc == count_q) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_DONE;
					end else begin
						k_q     <= k_inc;
						state_q <= S_SRCH_A;
					end
				end
				S_CP_A: begin
					state_q <= S_CP_B;
				end
				S_CP_B: begin
					if (k_inc == count_q) begin
						k_q     <= '0;
						state_q <= S_WB_A;
					end else begin
						k_q     <= k_inc;
						state_q <= S_CP_A;
					end
				end
				S_WB_A: begin
					state_q <= S_WB_B;
				end
				S_WB_B: begin
					k_q <= k_inc;
					if (k_inc == lim_q) begin
						cap_q   <= new_cap_q;
						head_q  <= '0;
						state_q <= (op_q == OP_PUSH_BACK || op_q == OP_PUSH_FRONT)
						           ? S_PUSH : S_DONE;
					end else begin
						state_q <= S_WB_A;
					end
				end
				S_PUSH: begin
					count_q <= count_q + CNT_W'(1);
					if (op_q == OP_PUSH_FRONT) begin
						head_q <= slot;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cap_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cap_q)) else $error("capacity is not a power of two");
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q) else $error("count exceeds capacity");
	a_head_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < cap_q) else $error("head slot beyond capacity");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |-> count_q < cap_q) else $error("push without room");

endmodule

/* hw/rtl/circular_deque_with_resize_core.sv */
// Top level of the circular deque with resize: store and scratch RAMs,
// sequencer and result register. Depends on cdq_pkg, cdq_ram and cdq_seq.

// One operation is taken at a time. A search examines elements in order until
// it finds a match or reaches the count; a resize copies each element out to
// the scratch RAM, then writes back every slot of the larger of old and new
// capacity; clear sweeps every slot of the current capacity. These loops step
// through the store one slot at a time. After reset the store is swept to zero
// over all 1024 slots, during which no item is accepted.
// A finished result sits in an output register, so the next transfer can be
// accepted while it waits.
module circular_deque_with_resize_core import cdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [ADDR_W-1:0] position,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [DATA_W-1:0] read_data,
	output logic [ADDR_W-1:0] found_position,
	output logic [CNT_W-1:0]  count_now,
	output logic [CNT_W-1:0]  capacity_now
);

	mem_req_t          st_req;
	mem_req_t          scr_req;
	logic [DATA_W-1:0] st_rdata;
	logic [DATA_W-1:0] scr_rdata;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	cdq_ram #(.DEPTH(MAX_CAP), .WIDTH(DATA_W)) u_store (
		.clk   (clk),
		.we    (st_req.we),
		.waddr (st_req.waddr),
		.wdata (st_req.wdata),
		.raddr (st_req.raddr),
		.rdata (st_rdata)
	);

	cdq_ram #(.DEPTH(MAX_CAP), .WIDTH(DATA_W)) u_scratch (
		.clk   (clk),
		.we    (scr_req.we),
		.waddr (scr_req.waddr),
		.wdata (scr_req.wdata),
		.raddr (scr_req.raddr),
		.rdata (scr_rdata)
	);

	cdq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.position  (position),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.st_req    (st_req),
		.st_rdata  (st_rdata),
		.scr_req   (scr_req),
		.scr_rdata (scr_rdata)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign read_data      = out_q.read_data;
	assign found_position = out_q.found_position;
	assign count_now      = out_q.count_now;
	assign capacity_now   = out_q.capacity_now;

endmodule

/* bench/circular_deque_with_resize_core_tb.sv */
// Self-checking testbench for circular_deque_with_resize_core.
// Holds a scoreboard class that tracks the deque's contents and predicts
// each result. Depends on cdq_pkg and the core RTL only.
module circular_deque_with_resize_core_tb;
	import cdq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class deque_scoreboard;
		logic [DATA_W-1:0] slots[MAX_CAP];
		int head;
		int fill;
		int cap;
		int peak_cap;
		int errors;
		int checked;
		int accepted;
		res_t awaiting[$];

		function new();
			errors = 0;
			checked = 0;
			accepted = 0;
			peak_cap = MIN_CAP;
			clear_all();
		endfunction

		function void clear_all();
			foreach (slots[i]) slots[i] = '0;
			head = 0;
			fill = 0;
			cap = MIN_CAP;
		endfunction

		function int slot_at(int logical);
			return (head + logical) & (cap - 1);
		endfunction

		// Re-pack so that the head lands on slot 0; all other slots become zero.
		function void repack(int new_cap);
			logic [DATA_W-1:0] tmp[$];
			for (int k = 0; k < fill; k++) tmp.push_back(slots[slot_at(k)]);
			foreach (slots[i]) slots[i] = '0;
			for (int k = 0; k < fill; k++) slots[k] = tmp[k];
			cap = new_cap;
			head = 0;
			if (cap > peak_cap) peak_cap = cap;
		endfunction

		function bit room_for_one();
			if (fill < cap) return 1;
			if (cap * 2 > MAX_CAP) return 0;
			repack(cap * 2);
			return 1;
		endfunction

		function void shrink_check();
			if (cap > MIN_CAP && fill < cap / 4) repack(cap / 2);
		endfunction

		function logic [DATA_W-1:0] element(int k);
			return slots[slot_at(k)];
		endfunction

		function void note_input(logic [2:0] op, logic [ADDR_W-1:0] pos,
				logic [DATA_W-1:0] val);
			res_t e;
			int p;
			e = '0;
			p = pos;
			accepted++;
			case (op) inside
				OP_PUSH_BACK: begin
					if (!room_for_one()) e.status = ST_FULL;
					else begin
						slots[slot_at(fill)] = val;
						fill++;
					end
				end
				OP_PUSH_FRONT: begin
					if (!room_for_one()) e.status = ST_FULL;
					else begin
						head = (head + cap - 1) & (cap - 1);
						slots[head] = val;
						fill++;
					end
				end
				OP_POP_BACK, OP_POP_FRONT: begin
					if (fill == 0) e.status = ST_EMPTY;
					else begin
						if (op == OP_POP_FRONT) head = (head + 1) & (cap - 1);
						fill--;
						shrink_check();
					end
				end
				OP_READ: begin
					if (p >= cap) e.status = ST_RANGE;
					else e.read_data = slots[slot_at(p)];
				end
				OP_WRITE: begin
					if (p >= cap) e.status = ST_RANGE;
					else slots[slot_at(p)] = val;
				end
				OP_SEARCH: begin
					e.status = ST_NOTFOUND;
					for (int k = 0; k < fill; k++) begin
						if (slots[slot_at(k)] == val) begin
							e.status = ST_OK;
							e.found_position = ADDR_W'(k);
							break;
						end
					end
				end
				default: clear_all();
			endcase
			e.count_now = CNT_W'(fill);
			e.capacity_now = CNT_W'(cap);
			awaiting.push_back(e);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (awaiting.size() == 0) begin
				$display("%0t: unexpected result transfer, status %0d", $time, got.status);
				errors++;
				return;
			end
			e = awaiting.pop_front();
			checked++;
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.read_data !== e.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time, e.read_data,
					got.read_data);
				errors++;
			end
			if (got.found_position !== e.found_position) begin
				$display("%0t: found_position expected %0d actual %0d", $time,
					e.found_position, got.found_position);
				errors++;
			end
			if (got.count_now !== e.count_now) begin
				$display("%0t: count_now expected %0d actual %0d", $time, e.count_now,
					got.count_now);
				errors++;
			end
			if (got.capacity_now !== e.capacity_now) begin
				$display("%0t: capacity_now expected %0d actual %0d", $time,
					e.capacity_now, got.capacity_now);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        opcode;
	logic [ADDR_W-1:0] position;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic [DATA_W-1:0] read_data;
	logic [ADDR_W-1:0] found_position;
	logic [CNT_W-1:0]  count_now;
	logic [CNT_W-1:0]  capacity_now;

	deque_scoreboard sb;
	bit hold_output;

	circular_deque_with_resize_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_data(read_data), .found_position(found_position),
		.count_now(count_now), .capacity_now(capacity_now)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#300ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one operation and hold it until the transfer happens.
	task automatic send_op(logic [2:0] op, logic [ADDR_W-1:0] pos, logic [DATA_W-1:0] val);
		int gap;
		in_valid <= 1'b1;
		opcode   <= op;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, pos, val);
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random stalls, free-running stretches, and one long hold.
	initial begin
		int stall_left;
		int free_left;
		res_t got;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.status = status;
				got.read_data = read_data;
				got.found_position = found_position;
				got.count_now = count_now;
				got.capacity_now = capacity_now;
				sb.check_result(got);
			end
			if (hold_output) begin
				hold_output = 1'b0;
				stall_left = 3000;
				free_left = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0) begin
				out_stall <= 1'b0;
				free_left--;
			end else begin
				stall_left = idle_length();
				free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(1, 12);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int r;
		int pos_pick;
		logic [2:0] op;
		logic [DATA_W-1:0] val;
		sb = new();
		hold_output = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_PUSH_BACK;
		position = '0;
		value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pops, range limits, slots beyond the count, extremes of the data.
		send_op(OP_POP_BACK, '0, '0);
		send_op(OP_POP_FRONT, '0, '0);
		send_op(OP_SEARCH, '0, '0);
		send_op(OP_READ, 10'd1, '0);
		send_op(OP_READ, 10'd2, '0);
		send_op(OP_WRITE, 10'd1023, 32'h1234_5678);
		send_op(OP_READ, 10'd1023, '0);
		send_op(OP_WRITE, 10'd1, 32'hFFFF_FFFF);
		send_op(OP_READ, 10'd1, '0);
		send_op(OP_PUSH_BACK, '0, 32'h0000_0000);
		send_op(OP_PUSH_FRONT, 10'h3FF, 32'hFFFF_FFFF);
		send_op(OP_PUSH_FRONT, '0, 32'hA5A5_5A5A);
		send_op(OP_SEARCH, '0, 32'hFFFF_FFFF);
		send_op(OP_SEARCH, '0, 32'h0000_0001);
		send_op(OP_READ, 10'd3, '0);
		send_op(OP_POP_FRONT, '0, '0);
		send_op(OP_POP_BACK, '0, '0);
		send_op(OP_POP_BACK, '0, '0);
		send_op(OP_CLEAR, 10'h155, 32'h5555_5555);
		send_op(OP_READ, 10'd0, '0);

		// Grow to the maximum capacity, then push into a full deque.
		for (int i = 0; i < MAX_CAP; i++)
			send_op((i % 3 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, ADDR_W'($urandom),
				$urandom);
		send_op(OP_PUSH_BACK, '0, 32'hDEAD_BEEF);
		send_op(OP_PUSH_FRONT, '0, 32'hDEAD_BEEF);
		send_op(OP_SEARCH, '0, sb.element(MAX_CAP - 1));
		send_op(OP_SEARCH, '0, sb.element(517));
		send_op(OP_WRITE, 10'h2AA, $urandom);
		send_op(OP_READ, 10'h2AA, '0);
		send_op(OP_READ, 10'h3FF, '0);
		send_op(OP_CLEAR, '0, '0);

		// Random mix; the count drifts up to a few dozen and gets drained again.
		for (int i = 0; i < 420; i++) begin
			if (i == 120) hold_output = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 22) op = OP_PUSH_BACK;
			else if (r < 40) op = OP_PUSH_FRONT;
			else if (r < 55) op = OP_POP_BACK;
			else if (r < 70) op = OP_POP_FRONT;
			else if (r < 80) op = OP_READ;
			else if (r < 90) op = OP_WRITE;
			else if (r < 99) op = OP_SEARCH;
			else op = OP_CLEAR;
			if (sb.fill > 48 && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT))
				op = (r & 1) ? OP_POP_BACK : OP_POP_FRONT;
			pos_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_CAP - 1)
				: $urandom_range(0, sb.cap + 1);
			val = $urandom;
			if (op == OP_SEARCH && sb.fill > 0 && $urandom_range(0, 1))
				val = sb.element($urandom_range(0, sb.fill - 1));
			send_op(op, pos_pick[ADDR_W-1:0], val);
		end
		in_valid <= 1'b0;

		while (sb.awaiting.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d operations with %0d results checked; peak capacity %0d.",
			sb.accepted, sb.checked, sb.peak_cap);
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_seq.sv
hw/rtl/circular_deque_with_resize_core.sv
bench/circular_deque_with_resize_core_tb.sv
